[sv/tgql_pkg.sv]
// Shared types and constants for the text glyph quad layout unit.
package tgql_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_CHAR  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_FETCH,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } state_t;

    localparam logic [2:0] REG_FIRST_CODE  = 3'd0;
    localparam logic [2:0] REG_GRID_COLS   = 3'd1;
    localparam logic [2:0] REG_GRID_ROWS   = 3'd2;
    localparam logic [2:0] REG_CELL_WIDTH  = 3'd3;
    localparam logic [2:0] REG_CELL_HEIGHT = 3'd4;
    localparam logic [2:0] REG_SCALE       = 3'd5;
    localparam logic [2:0] REG_PROP        = 3'd6;

    typedef struct packed {
        logic [7:0] first_code;
        logic [8:0] grid_cols;
        logic [8:0] grid_rows;
        logic [8:0] cell_width;
        logic [8:0] cell_height;
        logic [11:0] scale;
        logic        proportional;
    } cfg_t;

    typedef struct packed {
        logic load;      // accept item, run mode 0/1/newline or start char
        logic div_step;
        logic fetch;
        logic mul;
        logic sum;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_char;   // captured item is a printable char
        logic div_done;
    } sts_t;

endpackage

[sv/tgql_ctrl.sv]
// Controller state machine sequencing one item through the datapath.
module tgql_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           out_busy,
    input  tgql_pkg::sts_t sts,
    output tgql_pkg::cmd_t cmd
);
    import tgql_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!sts.is_char) begin
                    state_next = ST_IDLE;
                end else if (sts.div_done) begin
                    state_next = ST_FETCH;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_FETCH: begin
                cmd.fetch = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

[sv/tgql_dp.sv]
// Datapath: width store, glyph index divider, multipliers and pen state.
module tgql_dp #(
    parameter int MAX_GLYPHS = 256
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  tgql_pkg::cfg_t cfg,
    input  tgql_pkg::cmd_t cmd,
    output tgql_pkg::sts_t sts,
    input  logic [1:0]     mode,
    input  logic [7:0]     char_code,
    input  logic [7:0]     glyph_slot,
    input  logic [7:0]     left_px,
    input  logic [8:0]     right_px,
    input  logic [15:0]    origin_x,
    input  logic [15:0]    origin_y,
    output logic [127:0]   result
);
    import tgql_pkg::*;

    localparam int AW = $clog2(MAX_GLYPHS);
    localparam int CW = $clog2(MAX_GLYPHS + 1);
    localparam int ND = 8;

    logic [7:0] left_mem [MAX_GLYPHS];
    logic [8:0] right_mem [MAX_GLYPHS];
    logic [7:0] left_rd_reg;
    logic [8:0] right_rd_reg;

    logic signed [23:0] pen_reg;
    logic signed [23:0] top_reg;
    logic signed [15:0] lleft_reg;
    logic               is_char_reg;
    logic [7:0]         gid_reg;
    logic [8:0]         cols_reg;
    logic [7:0]         quo_reg;
    logic [8:0]         rem_reg;
    logic [3:0]         dcnt_reg;
    logic [16:0]        u0_reg, v0_reg;
    logic signed [10:0] width_reg;
    logic [15:0]        tu0_reg, tu1_reg;
    logic signed [36:0] xq0_reg, xq1_reg;
    logic signed [24:0] hq_reg;
    logic [127:0]       res_reg;

    logic [8:0]          cols;
    logic [17:0]         count_raw;
    logic [CW-1:0]       count;
    logic signed [9:0]   id;
    logic [7:0]          gid;
    logic [20:0]         hscale;
    logic signed [25:0]  top_sum;
    logic [9:0]          rem_sh;
    logic                use_prop;
    logic signed [25:0]  pen_sum;

    function automatic logic [15:0] sat_floor(input logic signed [37:0] v);
        logic signed [29:0] f;
        f = 30'(v >>> 8);
        if (f > 30'sd32767) return 16'h7fff;
        if (f < -30'sd32768) return 16'h8000;
        return f[15:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        if (v > 26'sd8388607) return 24'sh7fffff;
        if (v < -26'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    assign cols      = (cfg.grid_cols == 9'd0) ? 9'd1 : cfg.grid_cols;
    assign count_raw = cols * cfg.grid_rows;
    assign count     = (count_raw > 18'(MAX_GLYPHS)) ? CW'(MAX_GLYPHS) : CW'(count_raw);
    assign id        = $signed({2'b00, char_code}) - $signed({2'b00, cfg.first_code});
    assign gid       = (id < 0 || 18'(id) >= 18'(count)) ? 8'd0 : id[7:0];
    assign hscale    = cfg.cell_height * cfg.scale;
    assign top_sum   = 26'(top_reg) + 26'(hscale);
    assign rem_sh    = {rem_reg, quo_reg[7]};
    assign use_prop  = cfg.proportional && (right_rd_reg != 9'd0) &&
                       (18'(gid_reg) < 18'(MAX_GLYPHS));
    assign pen_sum   = 26'(pen_reg) + 26'(width_reg);

    assign sts.is_char  = is_char_reg;
    assign sts.div_done = (dcnt_reg == 4'(ND));
    assign result       = res_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load && mode == MODE_LOAD && 18'(glyph_slot) < 18'(MAX_GLYPHS)) begin
            left_mem[AW'(glyph_slot)]  <= left_px;
            right_mem[AW'(glyph_slot)] <= right_px;
        end
        if (cmd.fetch) begin
            left_rd_reg  <= left_mem[AW'(gid_reg)];
            right_rd_reg <= right_mem[AW'(gid_reg)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_reg     <= '0;
            top_reg     <= '0;
            lleft_reg   <= '0;
            is_char_reg <= 1'b0;
            dcnt_reg    <= '0;
        end else begin
            if (cmd.load) begin
                is_char_reg <= 1'b0;
                dcnt_reg    <= '0;
                unique case (mode)
                    MODE_START: begin
                        lleft_reg <= origin_x;
                        top_reg   <= {origin_y, 8'd0};
                        pen_reg   <= '0;
                    end
                    MODE_CHAR: begin
                        if (char_code == NEWLINE_CODE) begin
                            top_reg <= sat24(top_sum);
                            pen_reg <= '0;
                        end else begin
                            is_char_reg <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.div_step) dcnt_reg <= dcnt_reg + 4'd1;
            if (cmd.sum) pen_reg <= sat24(pen_sum);
        end
    end

    // restoring division of glyph index by column count, one bit a cycle
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            gid_reg  <= gid;
            cols_reg <= cols;
            quo_reg  <= gid;
            rem_reg  <= '0;
        end
        if (cmd.div_step) begin
            if (rem_sh >= {1'b0, cols_reg}) begin
                rem_reg <= 9'(rem_sh - {1'b0, cols_reg});
                quo_reg <= {quo_reg[6:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[8:0];
                quo_reg <= {quo_reg[6:0], 1'b0};
            end
        end
        if (cmd.fetch) begin
            u0_reg <= 17'(rem_reg * cfg.cell_width);
            v0_reg <= 17'(quo_reg * cfg.cell_height);
        end
        if (cmd.mul) begin
            if (use_prop) begin
                width_reg <= $signed({2'b00, right_rd_reg}) - $signed({3'b000, left_rd_reg});
                tu0_reg   <= 16'(u0_reg + 17'(left_rd_reg));
                tu1_reg   <= 16'(u0_reg + 17'(right_rd_reg));
            end else begin
                width_reg <= $signed({2'b00, cfg.cell_width});
                tu0_reg   <= u0_reg[15:0];
                tu1_reg   <= 16'(u0_reg + 17'(cfg.cell_width));
            end
            xq0_reg <= 37'(pen_reg * $signed({1'b0, cfg.scale}));
            hq_reg  <= 25'(hscale);
        end
        if (cmd.sum) begin
            xq1_reg <= 37'(pen_sum * $signed({1'b0, cfg.scale}));
        end
        if (cmd.out_load) begin
            res_reg[15:0]    <= tu0_reg;
            res_reg[31:16]   <= tu1_reg;
            res_reg[47:32]   <= v0_reg[15:0];
            res_reg[63:48]   <= 16'(v0_reg + 17'(cfg.cell_height));
            res_reg[79:64]   <= sat_floor(38'(xq0_reg) + 38'($signed({lleft_reg, 8'd0})));
            res_reg[95:80]   <= sat_floor(38'(xq1_reg) + 38'($signed({lleft_reg, 8'd0})));
            res_reg[111:96]  <= sat_floor(38'(top_reg));
            res_reg[127:112] <= sat_floor(38'(top_reg) + 38'(hq_reg));
        end
    end
endmodule

[sv/text_glyph_quad_layout_unit.sv]
// Top level of the text glyph quad layout unit.
// Lays out character codes from a grid font atlas into textured quads.
// s_ channel: one transaction per item; tuser holds mode; tdata holds
//   char_code, glyph_slot, left_px, right_px, origin_x, origin_y from bit 0 up.
// m_ channel: one transaction per printable character, tdata holds
//   tex_u0, tex_u1, tex_v0, tex_v1, scr_x0, scr_x1, scr_y0, scr_y1.
// cfg channel: write register index cfg_index with cfg_data while idle.
// Mode 0, mode 1, newline and mode 3 give no result.
// A character passes these steps in order: accept, the serial
// column/row divider steps, divider finish, store read,
// multiply, sum, output load; the output register then holds the quad.
// The m_ register frees the datapath only after the prior quad is taken,
// so a stalled receiver holds the unit in its final state.
// Reset clears pen and line state and sets the configuration to its defaults;
// the width store holds no reset value.
module text_glyph_quad_layout_unit #(
    parameter int MAX_GLYPHS = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,  // mode
    input  logic [71:0]  s_tdata,  // char_code, glyph_slot, left_px, right_px,
                                   // origin_x, origin_y, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // tex_u0, tex_u1, tex_v0, tex_v1,
                                   // scr_x0, scr_x1, scr_y0, scr_y1
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [11:0]  cfg_data
);
    import tgql_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;
    logic m_tvalid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{8'd32, 9'd16, 9'd16, 9'd16, 9'd16, 12'd256, 1'b0};
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FIRST_CODE:  cfg_reg.first_code  <= cfg_data[7:0];
                REG_GRID_COLS:   cfg_reg.grid_cols   <= cfg_data[8:0];
                REG_GRID_ROWS:   cfg_reg.grid_rows   <= cfg_data[8:0];
                REG_CELL_WIDTH:  cfg_reg.cell_width  <= cfg_data[8:0];
                REG_CELL_HEIGHT: cfg_reg.cell_height <= cfg_data[8:0];
                REG_SCALE:       cfg_reg.scale       <= cfg_data;
                REG_PROP:        cfg_reg.proportional <= cfg_data[0];
                default: ;
            endcase
        end
    end

    tgql_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .out_busy(m_tvalid_reg && !m_tready), .sts(sts), .cmd(cmd)
    );

    tgql_dp #(.MAX_GLYPHS(MAX_GLYPHS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .cmd(cmd), .sts(sts),
        .mode(s_tuser), .char_code(s_tdata[7:0]), .glyph_slot(s_tdata[15:8]),
        .left_px(s_tdata[23:16]), .right_px(s_tdata[32:24]),
        .origin_x(s_tdata[48:33]), .origin_y(s_tdata[64:49]), .result(m_tdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end
    assign m_tvalid = m_tvalid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_tvalid_reg && !m_tready))
        else $error("result overwritten while stalled");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("controller issued two commands");
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> s_tready && s_tvalid)
        else $error("load without accept");
endmodule

[tb/sv/testbench.sv]
// Testbench for the text glyph quad layout unit: directed table plus random strings.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tgql_pkg::*;

    localparam int LIMIT = 600000;

    typedef struct {
        logic [1:0]        mode;
        logic [7:0]        code;
        logic [7:0]        slot;
        logic [7:0]        left;
        logic [8:0]        right;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
    } glyph_req_t;

    typedef struct {
        glyph_req_t   req;
        bit           typed;
        logic [127:0] quad;
    } glyph_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [1:0]   s_tuser;
    logic [71:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [11:0]  cfg_data;

    text_glyph_quad_layout_unit dut (.*);

    int           first_code, grid_cols, grid_rows, cell_w, cell_h, scale, prop;
    logic [7:0]   left_store [256];
    logic [8:0]   right_store [256];
    longint       pen, line_top, line_left;
    logic [127:0] quad_queue [$];
    int           errors;
    int           mismatches;
    int           cycles;
    bit           quiet;
    bit           hold_req;

    string field_name [8] = '{"tex_u0", "tex_u1", "tex_v0", "tex_v1",
                              "scr_x0", "scr_x1", "scr_y0", "scr_y1"};

    glyph_row_t dir_tab [16] = '{
        '{'{MODE_START, 8'd0, 8'd0, 8'd0, 9'd0, 16'sd0, 16'sd0}, 1'b0, 128'd0},
        '{'{MODE_CHAR, 8'd65, 8'd0, 8'd0, 9'd0, 16'sd0, 16'sd0}, 1'b1,
          {16'd16, 16'd0, 16'd16, 16'd0, 16'd48, 16'd32, 16'd32, 16'd16}},
        '{'{MODE_CHAR, 8'd0, 8'd0, 8'd0, 9'd0, 16'sd0, 16'sd0}, 1'b1,
          {16'd16, 16'd0, 16'd32, 16'd16, 16'd16, 16'd0, 16'd16, 16'd0}},
        '{'{MODE_CHAR, NEWLINE_CODE, 8'd0, 8'd0, 9'd0, 16'sd0, 16'sd0}, 1'b0, 128'd0},
        '{'{MODE_CHAR, 8'd255, 8'd0, 8'd0, 9'd0, 16'sd0, 16'sd0}, 1'b0, 128'd0},
        '{'{MODE_CHAR, 8'd31, 8'd0, 8'd0, 9'd0, 16'sd0, 16'sd0}, 1'b0, 128'd0},
        '{'{MODE_NONE, 8'd65, 8'd3, 8'd1, 9'd2, 16'sd5, 16'sd5}, 1'b0, 128'd0},
        '{'{MODE_LOAD, 8'd0, 8'd255, 8'd255, 9'd256, 16'sd0, 16'sd0}, 1'b0, 128'd0},
        '{'{MODE_LOAD, 8'd0, 8'd0, 8'd0, 9'd0, 16'sd0, 16'sd0}, 1'b0, 128'd0},
        '{'{MODE_START, 8'd0, 8'd0, 8'd0, 9'd0, 16'sd32767, -16'sd32768}, 1'b0, 128'd0},
        '{'{MODE_CHAR, 8'd32, 8'd0, 8'd0, 9'd0, 16'sd0, 16'sd0}, 1'b1,
          {16'h8010, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd16, 16'd0, 16'd16, 16'd0}},
        '{'{MODE_CHAR, NEWLINE_CODE, 8'd0, 8'd0, 9'd0, 16'sd0, 16'sd0}, 1'b0, 128'd0},
        '{'{MODE_CHAR, 8'd126, 8'd0, 8'd0, 9'd0, 16'sd0, 16'sd0}, 1'b0, 128'd0},
        '{'{MODE_START, 8'd0, 8'd0, 8'd0, 9'd0, -16'sd32768, 16'sd32767}, 1'b0, 128'd0},
        '{'{MODE_CHAR, 8'd122, 8'd0, 8'd0, 9'd0, 16'sd0, 16'sd0}, 1'b0, 128'd0},
        '{'{MODE_CHAR, NEWLINE_CODE, 8'd0, 8'd0, 9'd0, 16'sd0, 16'sd0}, 1'b0, 128'd0}
    };

    function automatic longint sat24(input longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic logic [15:0] px16(input longint q8);
        longint v;
        v = q8 >>> 8;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic bit layout_quad(input glyph_req_t r, output logic [127:0] q);
        longint cols, cnt, gid, u0, u1, v0, wd, base;
        q = '0;
        case (r.mode)
            MODE_LOAD: begin
                left_store[r.slot] = r.left;
                right_store[r.slot] = r.right;
            end
            MODE_START: begin
                line_left = longint'(r.ox);
                line_top = longint'(r.oy) * 256;
                pen = 0;
            end
            MODE_CHAR: begin
                if (r.code == NEWLINE_CODE) begin
                    line_top = sat24(line_top + longint'(cell_h) * scale);
                    pen = 0;
                end else begin
                    cols = (grid_cols == 0) ? 1 : grid_cols;
                    cnt = cols * grid_rows;
                    if (cnt > 256) cnt = 256;
                    gid = longint'(r.code) - first_code;
                    if (gid < 0 || gid >= cnt) gid = 0;
                    u0 = (gid % cols) * cell_w;
                    v0 = (gid / cols) * cell_h;
                    if (prop != 0 && right_store[gid] != 0) begin
                        wd = longint'(right_store[gid]) - left_store[gid];
                        u1 = u0 + right_store[gid];
                        u0 = u0 + left_store[gid];
                    end else begin
                        wd = cell_w;
                        u1 = u0 + cell_w;
                    end
                    base = line_left * 256;
                    q[15:0] = u0[15:0];
                    q[31:16] = u1[15:0];
                    q[47:32] = v0[15:0];
                    q[63:48] = 16'(v0 + cell_h);
                    q[79:64] = px16(base + pen * scale);
                    q[95:80] = px16(base + (pen + wd) * scale);
                    q[111:96] = px16(line_top);
                    q[127:112] = px16(line_top + longint'(cell_h) * scale);
                    pen = sat24(pen + wd);
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        logic [127:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (quad_queue.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected quad: expected none got %h", m_tdata);
            end else begin
                want = quad_queue.pop_front();
                for (int k = 0; k < 8; k++) begin
                    if (m_tdata[k*16 +: 16] !== want[k*16 +: 16]) begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%s mismatch: expected %h got %h", field_name[k],
                                     want[k*16 +: 16], m_tdata[k*16 +: 16]);
                    end
                end
            end
        end
    end

    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (400) @(negedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    task automatic send_req(input glyph_req_t r, input bit typed, input logic [127:0] fixed);
        logic [127:0] q;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = r.mode;
        s_tdata = {7'd0, r.oy, r.ox, r.right, r.left, r.slot, r.code};
        do @(posedge aclk); while (!s_tready);
        if (layout_quad(r, q))
            quad_queue.push_back(typed ? fixed : q);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        while (quad_queue.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val[11:0];
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_FIRST_CODE:  first_code = val & 8'hFF;
            REG_GRID_COLS:   grid_cols = val & 9'h1FF;
            REG_GRID_ROWS:   grid_rows = val & 9'h1FF;
            REG_CELL_WIDTH:  cell_w = val & 9'h1FF;
            REG_CELL_HEIGHT: cell_h = val & 9'h1FF;
            REG_SCALE:       scale = val & 12'hFFF;
            REG_PROP:        prop = val & 1;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_setting(input int fc, input int gc, input int gr, input int cw,
                                input int ch, input int sc, input int pr);
        write_reg(REG_FIRST_CODE, fc);
        write_reg(REG_GRID_COLS, gc);
        write_reg(REG_GRID_ROWS, gr);
        write_reg(REG_CELL_WIDTH, cw);
        write_reg(REG_CELL_HEIGHT, ch);
        write_reg(REG_SCALE, sc);
        write_reg(REG_PROP, pr);
    endtask

    task automatic random_string_run(input int n);
        glyph_req_t r;
        int         cnt;
        int         pick;
        cnt = grid_cols * grid_rows;
        if (cnt > 256) cnt = 256;
        for (int i = 0; i < n; i++) begin
            r.mode = MODE_CHAR;
            r.code = 8'($urandom_range(0, 255));
            r.slot = 8'($urandom_range(0, 255));
            r.left = 8'($urandom_range(0, 255));
            r.right = 9'($urandom_range(0, 256));
            r.ox = 16'($urandom);
            r.oy = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                r.code = 8'(first_code + $urandom_range(0, cnt - 1));
            end else if (pick < 70) begin
                r.code = NEWLINE_CODE;
            end else if (pick < 80) begin
                r.mode = MODE_START;
                if ($urandom_range(0, 1) == 0) begin
                    r.ox = 16'($urandom_range(0, 400) - 200);
                    r.oy = 16'($urandom_range(0, 400) - 200);
                end
            end else if (pick < 90) begin
                r.mode = MODE_LOAD;
                if ($urandom_range(0, 1) == 0) r.left = 8'($urandom_range(0, 8));
            end else if (pick < 95) begin
                r.mode = MODE_NONE;
            end
            send_req(r, 1'b0, '0);
        end
    endtask

    initial begin
        glyph_req_t r;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        mismatches = 0;
        cycles = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        first_code = 32; grid_cols = 16; grid_rows = 16;
        cell_w = 16; cell_h = 16; scale = 256; prop = 0;
        pen = 0; line_top = 0; line_left = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int s = 0; s < 256; s++) begin
            r.mode = MODE_LOAD;
            r.code = 8'($urandom);
            r.slot = 8'(s);
            r.left = 8'($urandom_range(0, 255));
            r.right = 9'($urandom_range(0, 256));
            if (s % 3 == 0) r.left = 8'($urandom_range(0, 6));
            r.ox = 16'($urandom);
            r.oy = 16'($urandom);
            send_req(r, 1'b0, '0);
        end
        foreach (dir_tab[i])
            send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].quad);
        settle();

        hold_req = 1'b1;
        random_string_run(90);
        settle();
        load_setting(0, 1, 1, 1, 1, 1, 1);
        random_string_run(80);
        settle();
        load_setting(255, 256, 256, 256, 256, 4095, 1);
        random_string_run(80);
        settle();
        load_setting(32, 16, 16, 8, 12, 384, 1);
        random_string_run(90);
        settle();
        load_setting(40, 10, 20, 16, 16, 128, 0);
        random_string_run(80);
        settle();
        for (int p = 0; p < 3; p++) begin
            load_setting($urandom_range(0, 255), $urandom_range(1, 256),
                         $urandom_range(1, 256), $urandom_range(1, 256),
                         $urandom_range(1, 256), $urandom_range(1, 4095),
                         $urandom_range(0, 1));
            random_string_run(80);
            settle();
        end
        load_setting(32, 16, 16, 16, 16, 256, 1);
        quiet = 1'b1;
        random_string_run(80);
        settle();

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[text_glyph_quad_layout_unit.f]
sv/tgql_pkg.sv
sv/tgql_ctrl.sv
sv/tgql_dp.sv
sv/text_glyph_quad_layout_unit.sv
tb/sv/testbench.sv
